>>> rtl/core/pmft_pkg.sv
`default_nettype none
package pmft_pkg;

   localparam int POS_BITS = 11;
   localparam int SIZE_BITS = 11;
   localparam int DEPTH_DEF = 1024;
   localparam int VALUE_BITS_DEF = 64;

   typedef struct packed {
      logic load;
      logic issue;
      logic clr_step;
   } pmft_cmd_type;

   typedef struct packed {
      logic walk_active;
      logic clr_last;
      logic is_query;
   } pmft_status_type;

   // minus 1e18, or the most negative value when the word is too narrow
   function automatic logic signed [63:0] sentinel(input int vb);
      logic signed [63:0] s;
      if (vb >= 61) begin
         s = -64'sd1000000000000000000;
      end else begin
         s = -(64'sd1 <<< (vb - 1));
      end
      return s;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/pmft_ctrl.sv
`default_nettype none
module pmft_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire pmft_pkg::pmft_status_type status,
   output pmft_pkg::pmft_cmd_type        cmd,
   output logic                          busy,
   output logic                          rsp_strobe
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WALK  = 3'd2;
   localparam logic [2:0] ST_RESP  = 3'd3;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.issue    = 1'b0;
      cmd.clr_step = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.walk_active) begin
               cmd.issue = 1'b1;
            end else if (status.is_query) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = (state_ff == ST_RESP);

endmodule
`default_nettype wire

>>> rtl/core/pmft_dpath.sv
`default_nettype none
module pmft_dpath #(
   parameter int DEPTH      = pmft_pkg::DEPTH_DEF,
   parameter int VALUE_BITS = pmft_pkg::VALUE_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire pmft_pkg::pmft_cmd_type               cmd,
   output pmft_pkg::pmft_status_type                 status,
   input  wire logic                                 req_mode,
   input  wire logic [pmft_pkg::POS_BITS-1:0]        req_position,
   input  wire logic signed [VALUE_BITS-1:0]         req_value,
   input  wire logic                                 csr_valid,
   input  wire logic [pmft_pkg::SIZE_BITS-1:0]       csr_data,
   output logic signed [VALUE_BITS-1:0]              rsp_prefix_max,
   output logic                                      rsp_empty_res
);

   localparam int AW = $clog2(DEPTH);
   localparam int NW = ($clog2(DEPTH + 1) > pmft_pkg::POS_BITS) ?
                       $clog2(DEPTH + 1) : pmft_pkg::POS_BITS;
   localparam int IW = NW + 1;
   localparam int SIZE_MAX = (1 << pmft_pkg::SIZE_BITS) - 1;
   localparam logic [pmft_pkg::SIZE_BITS-1:0] SIZE_RST =
      pmft_pkg::SIZE_BITS'((DEPTH > SIZE_MAX) ? SIZE_MAX : DEPTH);
   localparam logic signed [VALUE_BITS-1:0] SENT =
      VALUE_BITS'(pmft_pkg::sentinel(VALUE_BITS));
   localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

   logic [pmft_pkg::SIZE_BITS-1:0] size_ff;
   logic [AW-1:0]                  clr_ff;
   logic [IW-1:0]                  idx_ff;
   logic                           mode_ff;
   logic                           ok_ff;
   logic signed [VALUE_BITS-1:0]   value_ff;
   logic signed [VALUE_BITS-1:0]   best_ff;
   logic                           rd_vld_ff;
   logic [AW-1:0]                  rd_addr_ff;
   logic signed [VALUE_BITS-1:0]   rdata_ff;
   logic signed [VALUE_BITS-1:0]   mem [DEPTH];

   logic [IW-1:0]                  size_ext;
   logic [IW-1:0]                  n_use;
   logic [IW-1:0]                  pos_ext;
   logic [IW-1:0]                  low_bit;
   logic [IW-1:0]                  idx_in;
   logic [AW-1:0]                  rd_addr_in;
   logic                           wr_en;
   logic [AW-1:0]                  wr_addr;
   logic signed [VALUE_BITS-1:0]   wr_data;
   logic                           raise;

   assign size_ext = IW'(size_ff);
   assign n_use    = (size_ext > IW'(DEPTH)) ? IW'(DEPTH) : size_ext;
   assign pos_ext  = IW'(req_position);
   assign low_bit  = idx_ff & (~idx_ff + IW'(1));
   assign rd_addr_in = AW'(idx_ff - IW'(1));

   assign status.walk_active = ok_ff && (idx_ff != '0) && (mode_ff || (idx_ff <= n_use));
   assign status.clr_last    = (clr_ff == CLR_LAST);
   assign status.is_query    = mode_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.load) begin
         idx_in = pos_ext;
      end else if (cmd.issue) begin
         idx_in = mode_ff ? (idx_ff - low_bit) : (idx_ff + low_bit);
      end
   end

   assign raise = rd_vld_ff && !mode_ff && (value_ff > rdata_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr_ff;
      wr_data = value_ff;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ff;
         wr_data = SENT;
      end else if (raise) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.issue) begin
         rdata_ff <= mem[rd_addr_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SIZE_RST;
         clr_ff    <= '0;
         rd_vld_ff <= 1'b0;
         ok_ff     <= 1'b0;
         mode_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            size_ff <= csr_data;
         end
         if (cmd.clr_step) begin
            clr_ff <= clr_ff + AW'(1);
         end
         rd_vld_ff <= cmd.issue;
         if (cmd.load) begin
            mode_ff <= req_mode;
            ok_ff   <= (pos_ext != '0) && (pos_ext <= n_use);
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.issue) begin
         rd_addr_ff <= rd_addr_in;
      end
      if (cmd.load) begin
         value_ff <= req_value;
         best_ff  <= SENT;
      end else if (rd_vld_ff && mode_ff && (rdata_ff > best_ff)) begin
         best_ff <= rdata_ff;
      end
   end

   assign rsp_prefix_max = best_ff;
   assign rsp_empty_res  = (best_ff == SENT);

endmodule
`default_nettype wire

>>> rtl/core/prefix_max_fenwick_tree.sv
// channel   ports                                  handshake
// request   req_mode, req_position, req_value      start high, busy low
// response  rsp_prefix_max, rsp_empty_res          rsp_strobe, one cycle, no stall
// csr       csr_data (table size)                  csr_valid and csr_ready
//
// an item visits k nodes while busy is high, and a query then adds a response
// beat; k is at most log2(DEPTH) + 1, with one node memory read a cycle and
// the raise or max in the cycle after each read
// after reset the node memory is swept to the sentinel with busy high
// csr_ready is always high; write the size only while busy is low
`default_nettype none
module prefix_max_fenwick_tree #(
   parameter int DEPTH      = pmft_pkg::DEPTH_DEF,
   parameter int VALUE_BITS = pmft_pkg::VALUE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_mode,
   input  wire logic [pmft_pkg::POS_BITS-1:0]     req_position,
   input  wire logic signed [VALUE_BITS-1:0]      req_value,
   output logic                                   rsp_strobe,
   output logic signed [VALUE_BITS-1:0]           rsp_prefix_max,
   output logic                                   rsp_empty_res,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [pmft_pkg::SIZE_BITS-1:0]    csr_data
);

   pmft_pkg::pmft_cmd_type    cmd;
   pmft_pkg::pmft_status_type status;

   assign csr_ready = 1'b1;

   pmft_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pmft_dpath #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .rsp_prefix_max (rsp_prefix_max),
      .rsp_empty_res  (rsp_empty_res)
   );

endmodule
`default_nettype wire
